/* hw/rtl/fcwb_pkg.sv */
// Shared types and constants for the four-corner weight balance conditioner.
// Depends on nothing; every other file refers to it by scoped names.
package fcwb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd4;

    // register widths
    localparam int THR_W   = 18;
    localparam int RATIO_W = 16;
    localparam int MAX_W   = 16;
    localparam int MIN_W   = 13;
    localparam int GAIN_W  = 8;

    // register reset values
    localparam logic [THR_W-1:0]   THR_RST   = 18'd500;
    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd8192;
    localparam logic [MAX_W-1:0]   MAX_RST   = 16'd4506;
    localparam logic [MIN_W-1:0]   MIN_RST   = 13'd3724;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd10;

    // Q4.12 result format
    localparam int Q_FRAC    = 12;
    localparam int MOD_W     = 16;
    localparam int DIV_CNT_W = 4;

    // side codes
    localparam int SIDE_W = 2;
    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

endpackage

/* hw/rtl/fcwb_if.sv */
// Channel interfaces: load sample beats, result beats, configuration writes.
// Depends on fcwb_pkg.
interface fcwb_in_if #(parameter int LOAD_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [LOAD_BITS-1:0] load_top_left;
    logic [LOAD_BITS-1:0] load_top_right;
    logic [LOAD_BITS-1:0] load_bottom_left;
    logic [LOAD_BITS-1:0] load_bottom_right;

    modport source (output valid, load_top_left, load_top_right, load_bottom_left,
                    load_bottom_right, input ready);
    modport sink (input valid, load_top_left, load_top_right, load_bottom_left,
                  load_bottom_right, output ready);
endinterface

interface fcwb_out_if;
    logic                        valid;
    logic                        ready;
    logic                        present;
    logic [fcwb_pkg::SIDE_W-1:0] raise_side;
    logic [fcwb_pkg::MOD_W-1:0]  mod_top_left;
    logic [fcwb_pkg::MOD_W-1:0]  mod_top_right;
    logic [fcwb_pkg::MOD_W-1:0]  mod_bottom_left;
    logic [fcwb_pkg::MOD_W-1:0]  mod_bottom_right;

    modport source (output valid, present, raise_side, mod_top_left, mod_top_right,
                    mod_bottom_left, mod_bottom_right, input ready);
    modport sink (input valid, present, raise_side, mod_top_left, mod_top_right,
                  mod_bottom_left, mod_bottom_right, output ready);
endinterface

interface fcwb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fcwb_pkg::CFG_IDX_W-1:0]  index;
    logic [fcwb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/fcwb_div.sv */
// Restoring divider with saturation: one quotient bit per cycle, MOD_W bits.
// Depends on fcwb_pkg (widths, div_stat_t).
module fcwb_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_W-1:0]                num,
    input  logic [DEN_W-1:0]                den,
    output fcwb_pkg::div_stat_t             stat,
    output logic [fcwb_pkg::MOD_W-1:0]      quo
);

    localparam int QW = fcwb_pkg::MOD_W;

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               sat_reg, sat_next;
    logic [fcwb_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DEN_W-1:0]                   rem_reg, rem_next;
    logic [DEN_W-1:0]                   den_reg, den_next;
    logic [QW-1:0]                      lo_reg, lo_next;
    logic [QW-1:0]                      q_reg, q_next;
    logic [DEN_W:0]                     rem_sh;
    logic                               ge;
    logic [NUM_W-1:0]                   num_hi;

    assign num_hi = num >> QW;
    assign rem_sh = {rem_reg, lo_reg[cnt_reg]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // sequencing of one division
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        if (start)
        begin
            q_next   = '0;
            cnt_next = fcwb_pkg::DIV_CNT_W'(QW - 1);
            den_next = den;
            lo_next  = num[QW-1:0];
            rem_next = num_hi[DEN_W-1:0];
            // zero divisor or quotient beyond MOD_W bits: saturate at once
            if ((den == '0) || (num_hi >= NUM_W'(den)))
            begin
                sat_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sat_reg  <= sat_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quo       = q_reg;

endmodule

/* hw/rtl/four_corner_weight_balance_conditioner.sv */
// Top level of the four-corner weight balance conditioner: ring memory, window
// sums, side choice and per-corner modulation. Depends on fcwb_pkg, fcwb_if, fcwb_div.
//
//  channel   dir  beat contents
//  samples   in   four corner loads, LOAD_BITS each
//  results   out  present, raise_side, four Q4.12 modulation values
//  cfg       in   register index, write data (always ready)
//
// results.valid rises after a sample accept once every corner, when someone is present,
// has run the full 16-step restoring divider or saturated at once; when nobody is
// present no division runs. The shared divider is run once per corner, one corner
// after another; one shared multiplier serves the side test and the numerator.
// samples.ready is low from accept until the result is loaded into the output register.
// A waiting result does not block the next beat; a second finished result waits for
// the output register to drain.
// Reset clears sums, ring position and registers; the ring memory needs no
// clearing pass, entries read as zero until the write position first wraps.
module four_corner_weight_balance_conditioner #(
    parameter int WINDOW_DEPTH = 256,
    parameter int LOAD_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    fcwb_in_if.sink     samples,
    fcwb_out_if.source  results,
    fcwb_cfg_if.sink    cfg
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = LOAD_BITS + SLOT_W;
    localparam int SIDE_SUM_W = LOAD_BITS + 1;
    localparam int TOT_W  = LOAD_BITS + 2;
    localparam int CMP_W  = (TOT_W > fcwb_pkg::THR_W) ? TOT_W : fcwb_pkg::THR_W;
    localparam int MA_W   = LOAD_BITS + fcwb_pkg::GAIN_W;
    localparam int MB_W   = (SIDE_SUM_W > fcwb_pkg::RATIO_W) ? SIDE_SUM_W
                                                             : fcwb_pkg::RATIO_W;
    localparam int P_W    = MA_W + MB_W;
    localparam int NUM_W  = P_W + fcwb_pkg::Q_FRAC;
    localparam int WORD_W = 4 * LOAD_BITS;
    localparam int MW     = fcwb_pkg::MOD_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPD   = 4'd1;
    localparam logic [3:0] S_SIDEA = 4'd2;
    localparam logic [3:0] S_SIDEB = 4'd3;
    localparam logic [3:0] S_SIDEC = 4'd4;
    localparam logic [3:0] S_GS    = 4'd5;
    localparam logic [3:0] S_NUM   = 4'd6;
    localparam logic [3:0] S_GO    = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]                      state_reg, state_next;
    logic [LOAD_BITS-1:0]            s_reg [4];
    logic [LOAD_BITS-1:0]            s_next [4];
    logic [SUM_W-1:0]                sums_reg [4];
    logic [SUM_W-1:0]                sums_next [4];
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    logic                            wrapped_reg, wrapped_next;
    logic                            present_reg, present_next;
    logic [SIDE_SUM_W-1:0]           left_reg, left_next;
    logic [SIDE_SUM_W-1:0]           right_reg, right_next;
    logic                            lflag_reg, lflag_next;
    logic [fcwb_pkg::SIDE_W-1:0]     raise_reg, raise_next;
    logic [1:0]                      corner_reg, corner_next;
    logic [P_W-1:0]                  prod_reg, prod_next;
    logic [NUM_W-1:0]                num_reg, num_next;
    logic [MW-1:0]                   mod_reg [4];
    logic [MW-1:0]                   mod_next [4];

    logic                            out_valid_reg, out_valid_next;
    logic                            out_present_reg, out_present_next;
    logic [fcwb_pkg::SIDE_W-1:0]     out_raise_reg, out_raise_next;
    logic [MW-1:0]                   out_mod_reg [4];
    logic [MW-1:0]                   out_mod_next [4];

    logic [fcwb_pkg::THR_W-1:0]      thr_reg, thr_next;
    logic [fcwb_pkg::RATIO_W-1:0]    ratio_reg, ratio_next;
    logic [fcwb_pkg::MAX_W-1:0]      max_reg, max_next;
    logic [fcwb_pkg::MIN_W-1:0]      min_reg, min_next;
    logic [fcwb_pkg::GAIN_W-1:0]     gain_reg, gain_next;

    logic [WORD_W-1:0]               ring_mem [WINDOW_DEPTH];
    logic [WORD_W-1:0]               rd_data_reg;
    logic [WORD_W-1:0]               wr_word;
    logic                            mem_we;
    logic                            in_acc;

    logic [MA_W-1:0]                 mul_a;
    logic [MB_W-1:0]                 mul_b;
    logic [P_W-1:0]                  mul_p;

    logic                            div_start;
    fcwb_pkg::div_stat_t             div_stat;
    logic [MW-1:0]                   div_quo;
    logic [MW-1:0]                   clamp_lo;
    logic [MW-1:0]                   clamp_val;
    logic [TOT_W-1:0]                total;

    assign in_acc        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;

    // ring memory: one word holds all four corners of a slot
    assign wr_word = {s_reg[3], s_reg[2], s_reg[1], s_reg[0]};
    assign mem_we  = (state_reg == S_UPD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[slot_reg] <= wr_word;
        end
        if (in_acc)
        begin
            rd_data_reg <= ring_mem[slot_reg];
        end
    end

    // shared multiplier, operands chosen by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SIDEA:
            begin
                mul_a = MA_W'(right_reg);
                mul_b = MB_W'(ratio_reg);
            end
            S_SIDEB:
            begin
                mul_a = MA_W'(left_reg);
                mul_b = MB_W'(ratio_reg);
            end
            S_GS:
            begin
                mul_a = MA_W'(gain_reg);
                mul_b = MB_W'(s_reg[corner_reg]);
            end
            S_NUM:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = MB_W'(WINDOW_DEPTH);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    // clamp of the quotient: min first, then max wins
    assign clamp_lo  = (div_quo < MW'(min_reg)) ? MW'(min_reg) : div_quo;
    assign clamp_val = (clamp_lo > max_reg) ? max_reg : clamp_lo;

    assign total = TOT_W'(s_reg[0]) + TOT_W'(s_reg[1]) + TOT_W'(s_reg[2])
                 + TOT_W'(s_reg[3]);

    assign div_start = (state_reg == S_GO);

    fcwb_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (sums_reg[corner_reg]),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        s_next       = s_reg;
        sums_next    = sums_reg;
        slot_next    = slot_reg;
        wrapped_next = wrapped_reg;
        present_next = present_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        lflag_next   = lflag_reg;
        raise_next   = raise_reg;
        corner_next  = corner_reg;
        prod_next    = prod_reg;
        num_next     = num_reg;
        mod_next     = mod_reg;

        out_valid_next   = out_valid_reg && !results.ready;
        out_present_next = out_present_reg;
        out_raise_next   = out_raise_reg;
        out_mod_next     = out_mod_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    s_next[0]  = samples.load_top_left;
                    s_next[1]  = samples.load_top_right;
                    s_next[2]  = samples.load_bottom_left;
                    s_next[3]  = samples.load_bottom_right;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                // oldest entry reads as zero until the ring has wrapped once
                for (int k = 0; k < 4; k++)
                begin
                    sums_next[k] = sums_reg[k] + SUM_W'(s_reg[k])
                                 - (wrapped_reg ? SUM_W'(rd_data_reg[k*LOAD_BITS +:
                                                                      LOAD_BITS])
                                                : SUM_W'(0));
                    mod_next[k] = '0;
                end
                if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                begin
                    slot_next    = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                present_next = (CMP_W'(total) >= CMP_W'(thr_reg));
                left_next    = SIDE_SUM_W'(s_reg[0]) + SIDE_SUM_W'(s_reg[2]);
                right_next   = SIDE_SUM_W'(s_reg[1]) + SIDE_SUM_W'(s_reg[3]);
                state_next   = S_SIDEA;
            end
            S_SIDEA:
            begin
                prod_next  = mul_p;
                state_next = S_SIDEB;
            end
            S_SIDEB:
            begin
                // 4096 * left > ratio * right
                lflag_next = ((P_W'(left_reg) << fcwb_pkg::Q_FRAC) > prod_reg);
                prod_next  = mul_p;
                state_next = S_SIDEC;
            end
            S_SIDEC:
            begin
                if (!present_reg)
                begin
                    raise_next = fcwb_pkg::SIDE_NONE;
                end
                else if (lflag_reg)
                begin
                    raise_next = fcwb_pkg::SIDE_LEFT;
                end
                else if (prod_reg < (P_W'(right_reg) << fcwb_pkg::Q_FRAC))
                begin
                    raise_next = fcwb_pkg::SIDE_RIGHT;
                end
                else
                begin
                    raise_next = fcwb_pkg::SIDE_NONE;
                end
                corner_next = 2'd0;
                state_next  = present_reg ? S_GS : S_DONE;
            end
            S_GS:
            begin
                prod_next  = mul_p;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                num_next   = NUM_W'(mul_p) << fcwb_pkg::Q_FRAC;
                state_next = S_GO;
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    mod_next[corner_reg] = div_stat.sat ? max_reg : clamp_val;
                    if (corner_reg == 2'd3)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 1'b1;
                        state_next  = S_GS;
                    end
                end
            end
            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_present_next = present_reg;
                    out_raise_next   = raise_reg;
                    out_mod_next     = mod_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        thr_next   = thr_reg;
        ratio_next = ratio_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        gain_next  = gain_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                fcwb_pkg::CFG_THRESHOLD: thr_next   = cfg.data[fcwb_pkg::THR_W-1:0];
                fcwb_pkg::CFG_RATIO:     ratio_next = cfg.data[fcwb_pkg::RATIO_W-1:0];
                fcwb_pkg::CFG_MAX:       max_next   = cfg.data[fcwb_pkg::MAX_W-1:0];
                fcwb_pkg::CFG_MIN:       min_next   = cfg.data[fcwb_pkg::MIN_W-1:0];
                fcwb_pkg::CFG_GAIN:      gain_next  = cfg.data[fcwb_pkg::GAIN_W-1:0];
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            corner_reg    <= 2'd0;
            for (int k = 0; k < 4; k++)
            begin
                sums_reg[k] <= '0;
            end
            thr_reg   <= fcwb_pkg::THR_RST;
            ratio_reg <= fcwb_pkg::RATIO_RST;
            max_reg   <= fcwb_pkg::MAX_RST;
            min_reg   <= fcwb_pkg::MIN_RST;
            gain_reg  <= fcwb_pkg::GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            wrapped_reg   <= wrapped_next;
            out_valid_reg <= out_valid_next;
            corner_reg    <= corner_next;
            sums_reg      <= sums_next;
            thr_reg       <= thr_next;
            ratio_reg     <= ratio_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            gain_reg      <= gain_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s_reg           <= s_next;
        present_reg     <= present_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        lflag_reg       <= lflag_next;
        raise_reg       <= raise_next;
        prod_reg        <= prod_next;
        num_reg         <= num_next;
        mod_reg         <= mod_next;
        out_present_reg <= out_present_next;
        out_raise_reg   <= out_raise_next;
        out_mod_reg     <= out_mod_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.present          = out_present_reg;
    assign results.raise_side       = out_raise_reg;
    assign results.mod_top_left     = out_mod_reg[0];
    assign results.mod_top_right    = out_mod_reg[1];
    assign results.mod_bottom_left  = out_mod_reg[2];
    assign results.mod_bottom_right = out_mod_reg[3];

endmodule

/* hw/rtl/fcwb_chk.sv */
// Port-level checker for the conditioner and its bind to the top level.
// Depends on fcwb_pkg and four_corner_weight_balance_conditioner.
module fcwb_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        present,
    input logic [fcwb_pkg::SIDE_W-1:0] raise_side,
    input logic [fcwb_pkg::MOD_W-1:0]  mod_top_left,
    input logic [fcwb_pkg::MOD_W-1:0]  mod_top_right,
    input logic [fcwb_pkg::MOD_W-1:0]  mod_bottom_left,
    input logic [fcwb_pkg::MOD_W-1:0]  mod_bottom_right
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(present)
            && $stable(raise_side) && $stable(mod_top_left) && $stable(mod_top_right)
            && $stable(mod_bottom_left) && $stable(mod_bottom_right))
        else $error("result beat changed while stalled");

    // absent beats carry all zero
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !present |-> raise_side == fcwb_pkg::SIDE_NONE
            && mod_top_left == '0 && mod_top_right == '0
            && mod_bottom_left == '0 && mod_bottom_right == '0)
        else $error("absent result not zero");

    // only the three side codes appear
    a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> raise_side == fcwb_pkg::SIDE_NONE
            || raise_side == fcwb_pkg::SIDE_LEFT || raise_side == fcwb_pkg::SIDE_RIGHT)
        else $error("bad raise_side code");

    // one sample beat at a time: not ready right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a sample accept");

endmodule

bind four_corner_weight_balance_conditioner fcwb_chk u_fcwb_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (samples.valid),
    .in_ready         (samples.ready),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .present          (results.present),
    .raise_side       (results.raise_side),
    .mod_top_left     (results.mod_top_left),
    .mod_top_right    (results.mod_top_right),
    .mod_bottom_left  (results.mod_bottom_left),
    .mod_bottom_right (results.mod_bottom_right)
);

/* verif/four_corner_weight_balance_conditioner_tb.sv */
// Testbench for the four-corner weight balance conditioner. It runs directed corner
// cases, then phased random load sequences, each checked beat by beat by a predictor.
// Depends on fcwb_pkg, fcwb_if and the RTL top level.
module four_corner_weight_balance_conditioner_tb;

    localparam int WINDOW          = 256;
    localparam int LOAD_W          = 16;
    localparam int CLK_HALF        = 6;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int CFG_W           = fcwb_pkg::CFG_DATA_W;

    // indexes past the register file, writes there must change nothing
    localparam logic [fcwb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [fcwb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LOAD_W-1:0] tl;
        logic [LOAD_W-1:0] tr;
        logic [LOAD_W-1:0] bl;
        logic [LOAD_W-1:0] br;
    } corner_loads_t;

    typedef struct packed {
        logic                        present;
        logic [fcwb_pkg::SIDE_W-1:0] side;
        logic [fcwb_pkg::MOD_W-1:0]  tl;
        logic [fcwb_pkg::MOD_W-1:0]  tr;
        logic [fcwb_pkg::MOD_W-1:0]  bl;
        logic [fcwb_pkg::MOD_W-1:0]  br;
    } balance_result_t;

    // Keeps its own windows and registers, predicts one result per sample beat
    class balance_scoreboard;
        logic [LOAD_W-1:0]            ring [4][WINDOW];
        logic [63:0]                  sums [4];
        int unsigned                  slot;
        logic [fcwb_pkg::THR_W-1:0]   thr_reg;
        logic [fcwb_pkg::RATIO_W-1:0] ratio_reg;
        logic [fcwb_pkg::MAX_W-1:0]   max_reg;
        logic [fcwb_pkg::MIN_W-1:0]   min_reg;
        logic [fcwb_pkg::GAIN_W-1:0]  gain_reg;
        balance_result_t              predicted_q [$];
        int                           mismatches;
        int                           checked;
        int                           n_absent;
        int                           n_left;
        int                           n_right;
        int                           n_level;
        int                           n_clamp_hi;

        function new();
            for (int k = 0; k < 4; k++)
            begin
                sums[k] = '0;
                for (int i = 0; i < WINDOW; i++)
                    ring[k][i] = '0;
            end
            slot       = 0;
            thr_reg    = fcwb_pkg::THR_RST;
            ratio_reg  = fcwb_pkg::RATIO_RST;
            max_reg    = fcwb_pkg::MAX_RST;
            min_reg    = fcwb_pkg::MIN_RST;
            gain_reg   = fcwb_pkg::GAIN_RST;
            mismatches = 0;
            checked    = 0;
            n_absent   = 0;
            n_left     = 0;
            n_right    = 0;
            n_level    = 0;
            n_clamp_hi = 0;
        endfunction

        function void write_reg(logic [fcwb_pkg::CFG_IDX_W-1:0] idx,
                                logic [fcwb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fcwb_pkg::CFG_THRESHOLD: thr_reg   = data[fcwb_pkg::THR_W-1:0];
                fcwb_pkg::CFG_RATIO:     ratio_reg = data[fcwb_pkg::RATIO_W-1:0];
                fcwb_pkg::CFG_MAX:       max_reg   = data[fcwb_pkg::MAX_W-1:0];
                fcwb_pkg::CFG_MIN:       min_reg   = data[fcwb_pkg::MIN_W-1:0];
                fcwb_pkg::CFG_GAIN:      gain_reg  = data[fcwb_pkg::GAIN_W-1:0];
                default:       ;
            endcase
        endfunction

        // gain * sample / average in Q4.12; lower clamp first, upper clamp wins
        function logic [fcwb_pkg::MOD_W-1:0] corner_mod(logic [63:0] sample,
                                                        logic [63:0] sum);
            logic [63:0] m;
            if (sum == 0)
                return max_reg;
            m = 64'(gain_reg) * sample * 64'(WINDOW) * 64'(1 << fcwb_pkg::Q_FRAC) / sum;
            if (m < 64'(min_reg))
                m = 64'(min_reg);
            if (m > 64'(max_reg))
                m = 64'(max_reg);
            return m[fcwb_pkg::MOD_W-1:0];
        endfunction

        function void note_sample(corner_loads_t ld);
            logic [63:0]     s [4];
            logic [63:0]     total;
            logic [63:0]     left;
            logic [63:0]     right;
            balance_result_t r;
            s[0] = 64'(ld.tl);
            s[1] = 64'(ld.tr);
            s[2] = 64'(ld.bl);
            s[3] = 64'(ld.br);
            // new sample replaces the oldest before the average is formed
            for (int k = 0; k < 4; k++)
            begin
                sums[k]       = sums[k] + s[k] - 64'(ring[k][slot]);
                ring[k][slot] = s[k][LOAD_W-1:0];
            end
            slot  = (slot + 1) % WINDOW;
            total = s[0] + s[1] + s[2] + s[3];
            r     = '0;
            if (total >= 64'(thr_reg))
            begin
                left      = s[0] + s[2];
                right     = s[1] + s[3];
                r.present = 1'b1;
                if (64'(1 << fcwb_pkg::Q_FRAC) * left > 64'(ratio_reg) * right)
                    r.side = fcwb_pkg::SIDE_LEFT;
                else if (left * 64'(ratio_reg) < 64'(1 << fcwb_pkg::Q_FRAC) * right)
                    r.side = fcwb_pkg::SIDE_RIGHT;
                else
                    r.side = fcwb_pkg::SIDE_NONE;
                r.tl = corner_mod(s[0], sums[0]);
                r.tr = corner_mod(s[1], sums[1]);
                r.bl = corner_mod(s[2], sums[2]);
                r.br = corner_mod(s[3], sums[3]);
                case (r.side)
                    fcwb_pkg::SIDE_LEFT:  n_left++;
                    fcwb_pkg::SIDE_RIGHT: n_right++;
                    default:              n_level++;
                endcase
                n_clamp_hi += (r.tl == max_reg) + (r.tr == max_reg)
                            + (r.bl == max_reg) + (r.br == max_reg);
            end
            else
                n_absent++;
            predicted_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(balance_result_t got);
            balance_result_t want;
            if (predicted_q.size() == 0)
            begin
                $error("result beat with nothing predicted: present=%0d side=%0d",
                       got.present, got.side);
                mismatches++;
                return;
            end
            want = predicted_q.pop_front();
            checked++;
            compare_field("present", 64'(want.present), 64'(got.present));
            compare_field("raise_side", 64'(want.side), 64'(got.side));
            compare_field("mod_top_left", 64'(want.tl), 64'(got.tl));
            compare_field("mod_top_right", 64'(want.tr), 64'(got.tr));
            compare_field("mod_bottom_left", 64'(want.bl), 64'(got.bl));
            compare_field("mod_bottom_right", 64'(want.br), 64'(got.br));
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet = 1'b0;

    balance_scoreboard board = new();

    fcwb_in_if #(.LOAD_BITS(LOAD_W)) samples_if ();
    fcwb_out_if                      results_if ();
    fcwb_cfg_if                      cfg_if ();

    four_corner_weight_balance_conditioner #(
        .WINDOW_DEPTH(WINDOW),
        .LOAD_BITS   (LOAD_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_if),
        .results(results_if),
        .cfg    (cfg_if)
    );

    always #(CLK_HALF) clk = ~clk;

    // idle length for one beat; about half the beats go back to back, all of them when quiet
    function automatic int unsigned draw_wait();
        if (quiet || $urandom_range(1) == 0)
            return 0;
        return $urandom_range(1, 19);
    endfunction

    function automatic logic [LOAD_W-1:0] sat16(int unsigned x);
        return (x > 65535) ? 16'hFFFF : x[LOAD_W-1:0];
    endfunction

    function automatic corner_loads_t loads(int unsigned tl, int unsigned tr,
                                            int unsigned bl, int unsigned br);
        corner_loads_t ld;
        ld.tl = tl[LOAD_W-1:0];
        ld.tr = tr[LOAD_W-1:0];
        ld.bl = bl[LOAD_W-1:0];
        ld.br = br[LOAD_W-1:0];
        return ld;
    endfunction

    // A person standing with some lean; now and then nobody, or raw noise
    function automatic corner_loads_t draw_loads(int unsigned body, int unsigned lean);
        int unsigned   roll;
        int unsigned   l;
        int unsigned   left;
        int unsigned   right;
        int unsigned   top_l;
        int unsigned   top_r;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 18)
            return loads($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                         $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        body  = body * $urandom_range(70, 130) / 100;
        l     = lean + $urandom_range(30);
        l     = (l > 15) ? l - 15 : 0;
        l     = (l > 100) ? 100 : l;
        left  = body * l / 100;
        right = body - left;
        top_l = $urandom_range(30, 70);
        top_r = $urandom_range(30, 70);
        return loads(sat16(left * top_l / 100), sat16(right * top_r / 100),
                     sat16(left - left * top_l / 100), sat16(right - right * top_r / 100));
    endfunction

    task automatic send_loads(corner_loads_t ld);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid             <= 1'b1;
        samples_if.load_top_left     <= ld.tl;
        samples_if.load_top_right    <= ld.tr;
        samples_if.load_bottom_left  <= ld.bl;
        samples_if.load_bottom_right <= ld.br;
        do @(posedge clk); while (!samples_if.ready);
        board.note_sample(ld);
    endtask

    // hold off until every predicted result is back, then let the block settle
    task automatic drain();
        samples_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(logic [fcwb_pkg::CFG_IDX_W-1:0] idx,
                               logic [fcwb_pkg::CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        board.write_reg(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_all(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] ratio,
                               logic [CFG_W-1:0] maxv, logic [CFG_W-1:0] minv,
                               logic [CFG_W-1:0] gain);
        program_reg(fcwb_pkg::CFG_THRESHOLD, thr);
        program_reg(fcwb_pkg::CFG_RATIO, ratio);
        program_reg(fcwb_pkg::CFG_MAX, maxv);
        program_reg(fcwb_pkg::CFG_MIN, minv);
        program_reg(fcwb_pkg::CFG_GAIN, gain);
    endtask

    // result side: random stalls, one beat checked per handshake
    initial
    begin : result_sink
        int unsigned     stall;
        balance_result_t got;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!results_if.valid);
            got.present = results_if.present;
            got.side    = results_if.raise_side;
            got.tl      = results_if.mod_top_left;
            got.tr      = results_if.mod_top_right;
            got.bl      = results_if.mod_bottom_left;
            got.br      = results_if.mod_bottom_right;
            board.check_result(got);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $error("timeout after %0d cycles, %0d results outstanding",
               CYCLE_LIMIT, board.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned phase_body;
        int unsigned phase_lean;
        samples_if.valid             <= 1'b0;
        samples_if.load_top_left     <= '0;
        samples_if.load_top_right    <= '0;
        samples_if.load_bottom_left  <= '0;
        samples_if.load_bottom_right <= '0;
        cfg_if.valid                 <= 1'b0;
        cfg_if.index                 <= '0;
        cfg_if.data                  <= '0;
        rst_n                        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero windows, threshold edges, side choices
        send_loads(loads(0, 0, 600, 0));
        send_loads(loads(0, 0, 0, 0));
        send_loads(loads(125, 125, 125, 124));
        send_loads(loads(125, 125, 125, 125));
        send_loads(loads(40000, 100, 40000, 100));
        send_loads(loads(100, 40000, 100, 40000));
        send_loads(loads(65535, 65535, 65535, 65535));
        send_loads(loads(1000, 0, 1000, 0));
        drain();

        // wide-open clamps, unit gain, zero threshold: empty scale counts as present
        program_all(18'd0, 18'd4096, 18'd65535, 18'd0, 18'd1);
        send_loads(loads(0, 0, 0, 0));
        send_loads(loads(65535, 1, 65535, 1));
        send_loads(loads(1, 65535, 1, 65535));
        send_loads(loads(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        send_loads(loads(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
        drain();

        // all-ones writes (max apart): bits above each register are dropped; min lands above max
        program_all(18'h3FFFF, 18'h3FFFF, 18'h30064, 18'h3FFFF, 18'h3FFFF);
        program_reg(CFG_SPARE_LO, 18'h00000);
        program_reg(CFG_SPARE_HI, 18'h15555);
        send_loads(loads(40000, 40000, 40000, 40000));
        drain();
        program_reg(fcwb_pkg::CFG_THRESHOLD, 18'd160000);
        send_loads(loads(40000, 40000, 40000, 40000));
        send_loads(loads(39999, 40000, 40000, 40000));
        send_loads(loads(52000, 36000, 40000, 32000));
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            quiet = 1'b0;
            case (ph)
                0: program_all(CFG_W'(fcwb_pkg::THR_RST), CFG_W'(fcwb_pkg::RATIO_RST),
                               CFG_W'(fcwb_pkg::MAX_RST), CFG_W'(fcwb_pkg::MIN_RST),
                               CFG_W'(fcwb_pkg::GAIN_RST));
                1: program_all(18'd0, 18'd4096, 18'd65535, 18'd0, 18'd1);
                2: program_all(CFG_W'($urandom_range(160000)),
                               CFG_W'($urandom_range(4096, 65535)),
                               CFG_W'($urandom_range(4096, 65535)),
                               CFG_W'($urandom_range(4096)),
                               CFG_W'($urandom_range(1, 8)));
                3: program_all(CFG_W'($urandom_range(3000)), 18'd4096, 18'd4096,
                               18'd4096, 18'd0);
                4:
                begin
                    program_all(CFG_W'($urandom_range(2000)), 18'd65535, 18'd65535,
                                18'd4096, 18'd255);
                    quiet = 1'b1;
                end
                default: program_all({2'b11, 16'($urandom_range(160000))},
                                     {2'b10, 16'($urandom_range(4096, 65535))},
                                     {2'b01, 16'($urandom_range(4096, 65535))},
                                     {5'b10101, 13'($urandom_range(4096))},
                                     {10'h2AB, 8'($urandom_range(2, 6))});
            endcase
            phase_body = (ph == 2 || ph == 5) ? $urandom_range(300, 160000)
                                               : $urandom_range(800, 60000);
            phase_lean = $urandom_range(100);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 20 == 19)
                    phase_lean = $urandom_range(100);
                send_loads(draw_loads(phase_body, phase_lean));
            end
            drain();
        end

        if (board.pending() != 0)
        begin
            $error("%0d predicted results never arrived", board.pending());
            board.mismatches++;
        end
        $display("Checked %0d result beats: %0d absent, %0d raise left,",
                 board.checked, board.n_absent, board.n_left);
        $display("%0d raise right, %0d level over %0d random register phases",
                 board.n_right, board.n_level, RANDOM_PHASES);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
